### rtl/lfftc_pkg.sv
package lfftc_pkg;

   // Register index codes of the configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_INERTIA         = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GRAVITY_MOMENT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_INV_TRANSMISSION = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DEAD_TORQUE     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_VEL_THRESHOLD   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_COMMAND     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_PERMILLE_SCALE  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_CLAMP_PERMILLE  = 3'd7;

   // pi/180 in Q60, 55 bits wide
   localparam logic [54:0] DEG_TO_RAD_Q60 = 55'(64'h1921FB54442D1847 / 64'd90);
   // pi/2 in Q30, for building the sine table
   localparam logic [63:0] HALF_PI_Q30 = 64'h6487ED51;
   localparam logic [63:0] SINE_ONE_Q30 = 64'h4000_0000;
   // Largest joint and friction torque magnitude
   localparam logic [30:0] TORQUE_LIMIT = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [31:0] inertia;
      logic [31:0] gravity_moment;
      logic [31:0] inverse_transmission;
      logic [31:0] dead_torque;
      logic [30:0] velocity_threshold;
      logic [30:0] max_command;
      logic [31:0] permille_per_newton_metre;
      logic [14:0] clamp_permille;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      inertia:                   32'd0,
      gravity_moment:            32'd0,
      inverse_transmission:      32'd16777216,
      dead_torque:               32'd10499,
      velocity_threshold:        31'd128,
      max_command:               31'd32768000,
      permille_per_newton_metre: 32'd65536000,
      clamp_permille:            15'd1000
   };

   typedef struct packed {
      logic signed [15:0] joint_angle;
      logic signed [31:0] joint_acceleration;
      logic signed [31:0] joint_velocity;
   } req_type;

   // Joint torque handed from the joint section to the motor section
   typedef struct packed {
      logic signed [31:0] joint_torque;
      logic [30:0]        joint_mag;
      logic               joint_neg;
      logic signed [31:0] friction_torque;
   } joint_type;

   typedef struct packed {
      logic signed [15:0] torque_permille;
      logic signed [31:0] motor_torque_command;
      logic signed [31:0] joint_feedforward_torque;
      logic signed [31:0] friction_torque;
   } rsp_type;

   // One quarter-wave sine entry in Q30, from a Taylor sum up to x^15
   function automatic logic [30:0] sine_entry(input int unsigned idx, input int unsigned tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x    = (64'(idx) * HALF_PI_Q30) >> tbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(SINE_ONE_Q30)) begin
         sum = longint'(SINE_ONE_Q30);
      end
      return 31'(sum);
   endfunction

endpackage

### rtl/lfftc_sine_rom.sv
module lfftc_sine_rom #(
   parameter int unsigned TABLE_BITS = 10
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [TABLE_BITS:0] rd_addr,
   output logic [30:0]         rd_data
);

   localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

   logic [30:0] rom [DEPTH];
   logic [30:0] data_ff;

   // Constant quarter-wave table, sin(pi/2 * i / 2^TABLE_BITS) in Q30
   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      assign rom[g] = lfftc_pkg::sine_entry(g, TABLE_BITS);
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

### rtl/lfftc_joint_path.sv
module lfftc_joint_path #(
   parameter int unsigned SINE_TABLE_BITS  = 10,
   parameter int unsigned TORQUE_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lfftc_pkg::cfg_type   cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lfftc_pkg::req_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lfftc_pkg::joint_type out_data
);

   localparam int unsigned NSTAGE = 8;
   localparam int unsigned IDX_W = SINE_TABLE_BITS + 1;
   localparam int unsigned QUARTER_SHIFT = 14 - SINE_TABLE_BITS;
   // Inertia product is Q92; the top 64 bits are taken, then HS more are dropped
   localparam int unsigned HS = 28 - TORQUE_FRAC_BITS;
   localparam logic [IDX_W-1:0] QUARTER = IDX_W'(1) << SINE_TABLE_BITS;
   localparam logic signed [57:0] JOINT_HI = 58'sd2147483647;
   localparam logic signed [57:0] JOINT_LO = -58'sd2147483647;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] stage_en;

   // Stage 0: magnitudes and table index
   logic [31:0]            acc_mag_in, acc_mag_ff;
   logic [31:0]            vel_mag_in, vel_mag_ff;
   logic [IDX_W-1:0]       sine_idx_in, sine_idx_ff;
   logic [SINE_TABLE_BITS-1:0] sine_step;
   logic                   acc_neg_ff, sin_neg_ff, vel_neg_ff, vel_nz_ff;
   // Stage 1
   logic [63:0]            acc_iner_in, acc_iner_ff;
   logic signed [31:0]     fric_in;
   logic [30:0]            dead_sat;
   logic [30:0]            sine_mag;
   logic signed [31:0]     fric_ff [1:NSTAGE-1];
   logic                   acc_neg1_ff, sin_neg1_ff;
   // Stage 2: partial products
   logic [63:0]            pp00_in, pp00_ff;
   logic [54:0]            pp01_in, pp01_ff;
   logic [63:0]            pp10_in, pp10_ff;
   logic [54:0]            pp11_in, pp11_ff;
   logic [62:0]            grav_prod_in, grav_prod_ff;
   logic                   acc_neg2_ff, sin_neg2_ff;
   // Stage 3
   logic [64:0]            mid_in, mid_ff;
   logic [32:0]            grav_in, grav_ff;
   logic [31:0]            pp00_hi_ff;
   logic [54:0]            pp11_d_ff;
   logic                   acc_neg3_ff, sin_neg3_ff;
   // Stage 4
   logic [32:0]            lo_sum;
   logic [55:0]            high_in, high_ff;
   logic signed [33:0]     grav_s_in, grav_s4_ff;
   logic                   acc_neg4_ff;
   // Stage 5
   logic [56:0]            iner_round;
   logic [55:0]            iner_in, iner_ff;
   logic signed [33:0]     grav_s5_ff;
   logic                   acc_neg5_ff;
   // Stage 6
   logic signed [57:0]     grav_ext, iner_ext;
   logic signed [57:0]     sum_in, sum_ff;
   // Stage 7
   logic signed [57:0]     sum_abs;
   logic signed [31:0]     joint_in, joint_ff;
   logic [30:0]            jmag_in, jmag_ff;
   logic                   jneg_ff;

   // Advance a stage when it is empty or the stage after it advances
   always_comb begin
      stage_en[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = {valid_ff[NSTAGE-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[NSTAGE-1];

   // Stage 0: take magnitudes, pick quadrant and table entry
   always_comb begin
      acc_mag_in = in_data.joint_acceleration[31] ?
                   (~in_data.joint_acceleration + 32'd1) : in_data.joint_acceleration;
      vel_mag_in = in_data.joint_velocity[31] ?
                   (~in_data.joint_velocity + 32'd1) : in_data.joint_velocity;
      sine_step  = in_data.joint_angle[13:QUARTER_SHIFT];
      sine_idx_in = in_data.joint_angle[14] ? (QUARTER - IDX_W'(sine_step))
                                            : IDX_W'(sine_step);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         acc_mag_ff  <= acc_mag_in;
         vel_mag_ff  <= vel_mag_in;
         sine_idx_ff <= sine_idx_in;
         acc_neg_ff  <= in_data.joint_acceleration[31];
         sin_neg_ff  <= in_data.joint_angle[15];
         vel_neg_ff  <= in_data.joint_velocity[31];
         vel_nz_ff   <= (in_data.joint_velocity != 32'sd0);
      end
   end

   // Stage 1: acceleration times inertia, sine read, friction select
   lfftc_sine_rom #(
      .TABLE_BITS(SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock  (clock),
      .rd_en  (stage_en[1]),
      .rd_addr(sine_idx_ff),
      .rd_data(sine_mag)
   );

   always_comb begin
      acc_iner_in = 64'(acc_mag_ff) * 64'(cfg.inertia);
      dead_sat    = cfg.dead_torque[31] ? lfftc_pkg::TORQUE_LIMIT : cfg.dead_torque[30:0];
      if ((vel_mag_ff >= {1'b0, cfg.velocity_threshold}) && vel_nz_ff) begin
         fric_in = vel_neg_ff ? (32'd0 - {1'b0, dead_sat}) : {1'b0, dead_sat};
      end else begin
         fric_in = 32'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         acc_iner_ff <= acc_iner_in;
         fric_ff[1]  <= fric_in;
         acc_neg1_ff <= acc_neg_ff;
         sin_neg1_ff <= sin_neg_ff;
      end
   end

   // Stage 2: split the wide product by the degree-to-radian scale, gravity moment times sine
   always_comb begin
      pp00_in = 64'(acc_iner_ff[31:0]) * 64'(lfftc_pkg::DEG_TO_RAD_Q60[31:0]);
      pp01_in = 55'(acc_iner_ff[31:0]) * 55'(lfftc_pkg::DEG_TO_RAD_Q60[54:32]);
      pp10_in = 64'(acc_iner_ff[63:32]) * 64'(lfftc_pkg::DEG_TO_RAD_Q60[31:0]);
      pp11_in = 55'(acc_iner_ff[63:32]) * 55'(lfftc_pkg::DEG_TO_RAD_Q60[54:32]);
      grav_prod_in = 63'(cfg.gravity_moment) * 63'(sine_mag);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         pp00_ff      <= pp00_in;
         pp01_ff      <= pp01_in;
         pp10_ff      <= pp10_in;
         pp11_ff      <= pp11_in;
         grav_prod_ff <= grav_prod_in;
         fric_ff[2]   <= fric_ff[1];
         acc_neg2_ff  <= acc_neg1_ff;
         sin_neg2_ff  <= sin_neg1_ff;
      end
   end

   // Stage 3: add the cross terms, round the gravity term from Q30
   always_comb begin
      mid_in  = 65'(pp01_ff) + 65'(pp10_ff);
      grav_in = 33'((64'(grav_prod_ff) + (64'd1 << 29)) >> 30);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         mid_ff      <= mid_in;
         grav_ff     <= grav_in;
         pp00_hi_ff  <= pp00_ff[63:32];
         pp11_d_ff   <= pp11_ff;
         fric_ff[3]  <= fric_ff[2];
         acc_neg3_ff <= acc_neg2_ff;
         sin_neg3_ff <= sin_neg2_ff;
      end
   end

   // Stage 4: upper 64 bits of the 128-bit product, signed gravity term
   always_comb begin
      lo_sum    = 33'(pp00_hi_ff) + 33'(mid_ff[31:0]);
      high_in   = 56'(pp11_d_ff) + 56'(mid_ff[64:32]) + 56'(lo_sum[32]);
      grav_s_in = sin_neg3_ff ? (34'd0 - {1'b0, grav_ff}) : {1'b0, grav_ff};
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         high_ff     <= high_in;
         grav_s4_ff  <= grav_s_in;
         fric_ff[4]  <= fric_ff[3];
         acc_neg4_ff <= acc_neg3_ff;
      end
   end

   // Stage 5: round the inertia term down to torque fraction bits
   always_comb begin
      iner_round = 57'(high_ff) + (57'd1 << (HS - 1));
      iner_in    = 56'(iner_round >> HS);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         iner_ff     <= iner_in;
         grav_s5_ff  <= grav_s4_ff;
         fric_ff[5]  <= fric_ff[4];
         acc_neg5_ff <= acc_neg4_ff;
      end
   end

   // Stage 6: joint torque sum
   always_comb begin
      grav_ext = 58'(grav_s5_ff);
      iner_ext = $signed({2'b00, iner_ff});
      sum_in   = acc_neg5_ff ? (grav_ext - iner_ext) : (grav_ext + iner_ext);
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         sum_ff     <= sum_in;
         fric_ff[6] <= fric_ff[5];
      end
   end

   // Stage 7: saturate the joint torque, keep its magnitude for scaling
   always_comb begin
      if (sum_ff > JOINT_HI) begin
         joint_in = 32'(JOINT_HI);
      end else if (sum_ff < JOINT_LO) begin
         joint_in = 32'(JOINT_LO);
      end else begin
         joint_in = sum_ff[31:0];
      end
      sum_abs = sum_ff[57] ? -sum_ff : sum_ff;
      jmag_in = (sum_abs > JOINT_HI) ? lfftc_pkg::TORQUE_LIMIT : sum_abs[30:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         joint_ff   <= joint_in;
         jmag_ff    <= jmag_in;
         jneg_ff    <= sum_ff[57];
         fric_ff[7] <= fric_ff[6];
      end
   end

   assign out_data.joint_torque    = joint_ff;
   assign out_data.joint_mag       = jmag_ff;
   assign out_data.joint_neg       = jneg_ff;
   assign out_data.friction_torque = fric_ff[NSTAGE-1];

endmodule

### rtl/lfftc_motor_path.sv
module lfftc_motor_path #(
   parameter int unsigned TORQUE_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lfftc_pkg::cfg_type   cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lfftc_pkg::joint_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lfftc_pkg::rsp_type   out_data
);

   localparam int unsigned NSTAGE = 7;
   localparam int unsigned PS = TORQUE_FRAC_BITS + 16;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] stage_en;

   logic signed [31:0] joint_ff [0:NSTAGE-1];
   logic signed [31:0] fric_ff  [0:NSTAGE-1];
   // Stage 0
   logic [62:0]        mprod_in, mprod_ff;
   logic               jneg0_ff, jneg1_ff;
   // Stage 1
   logic [39:0]        motor_in, motor_ff;
   // Stage 2
   logic signed [41:0] fric_ext, motor_ext;
   logic signed [41:0] craw_in, craw_ff;
   // Stage 3
   logic signed [41:0] max_ext, craw_abs;
   logic signed [31:0] cmd_in;
   logic [30:0]        cmag_in, cmag_ff;
   logic signed [31:0] cmd_ff [3:NSTAGE-1];
   logic               cneg_ff [3:NSTAGE-1];
   // Stage 4
   logic [62:0]        pprod_in, pprod_ff;
   // Stage 5
   logic [63:0]        pround;
   logic [14:0]        psat_in, psat_ff;
   // Stage 6
   logic signed [15:0] pm_in, pm_ff;

   // Advance a stage when it is empty or the stage after it advances
   always_comb begin
      stage_en[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = {valid_ff[NSTAGE-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[NSTAGE-1];

   // Carry joint and friction torque alongside
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         joint_ff[0] <= in_data.joint_torque;
         fric_ff[0]  <= in_data.friction_torque;
      end
      for (int k = 1; k < NSTAGE; k++) begin
         if (stage_en[k]) begin
            joint_ff[k] <= joint_ff[k-1];
            fric_ff[k]  <= fric_ff[k-1];
         end
      end
   end

   // Stage 0: scale the joint torque magnitude to the motor side
   assign mprod_in = 63'(in_data.joint_mag) * 63'(cfg.inverse_transmission);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mprod_ff <= mprod_in;
         jneg0_ff <= in_data.joint_neg;
      end
   end

   // Stage 1: round from Q24
   assign motor_in = 40'((64'(mprod_ff) + (64'd1 << 23)) >> 24);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         motor_ff <= motor_in;
         jneg1_ff <= jneg0_ff;
      end
   end

   // Stage 2: add friction to the signed motor torque
   always_comb begin
      fric_ext  = 42'(fric_ff[1]);
      motor_ext = $signed({2'b00, motor_ff});
      craw_in   = jneg1_ff ? (fric_ext - motor_ext) : (fric_ext + motor_ext);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         craw_ff <= craw_in;
      end
   end

   // Stage 3: clamp to the symmetric command limit
   always_comb begin
      max_ext = $signed({11'd0, cfg.max_command});
      if (craw_ff > max_ext) begin
         cmd_in = 32'(max_ext);
      end else if (craw_ff < -max_ext) begin
         cmd_in = 32'(-max_ext);
      end else begin
         cmd_in = craw_ff[31:0];
      end
      craw_abs = craw_ff[41] ? -craw_ff : craw_ff;
      cmag_in  = (craw_abs > max_ext) ? cfg.max_command : craw_abs[30:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         cmd_ff[3]  <= cmd_in;
         cneg_ff[3] <= craw_ff[41];
         cmag_ff    <= cmag_in;
      end
      for (int k = 4; k < NSTAGE; k++) begin
         if (stage_en[k]) begin
            cmd_ff[k]  <= cmd_ff[k-1];
            cneg_ff[k] <= cneg_ff[k-1];
         end
      end
   end

   // Stage 4: command magnitude times permille scale
   assign pprod_in = 63'(cmag_ff) * 63'(cfg.permille_per_newton_metre);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         pprod_ff <= pprod_in;
      end
   end

   // Stage 5: round and limit the permille magnitude
   always_comb begin
      pround  = (64'(pprod_ff) + (64'd1 << (PS - 1))) >> PS;
      psat_in = (pround > 64'(cfg.clamp_permille)) ? cfg.clamp_permille : pround[14:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         psat_ff <= psat_in;
      end
   end

   // Stage 6: apply the sign, hold the result for the consumer
   assign pm_in = cneg_ff[5] ? (16'd0 - {1'b0, psat_ff}) : {1'b0, psat_ff};

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         pm_ff <= pm_in;
      end
   end

   assign out_data.torque_permille          = pm_ff;
   assign out_data.motor_torque_command     = cmd_ff[NSTAGE-1];
   assign out_data.joint_feedforward_torque = joint_ff[NSTAGE-1];
   assign out_data.friction_torque          = fric_ff[NSTAGE-1];

endmodule

### rtl/link_feedforward_torque_command.sv
// Depth: a request passes through 15 register stages before its result is presented.
// Throughput: one request per cycle while rsp_tready is high, as rsp_tready low stalls
// the pipeline; the depth is set by four multiplier stages and the
// rounding, summing and clamping stages that follow each of them.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
// The sine table is a constant ROM and needs no clearing after reset.
module link_feedforward_torque_command #(
   parameter int unsigned SINE_TABLE_BITS  = 10,
   parameter int unsigned TORQUE_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // joint_angle [15:0], joint_acceleration [47:16], joint_velocity [79:48]
   input  logic [79:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // torque_permille [15:0], motor_torque_command [47:16],
   // joint_feedforward_torque [79:48], friction_torque [111:80]
   output logic [111:0]                     rsp_tdata,
   input  logic                             csr_we,
   input  logic [lfftc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0]                      csr_wdata
);

   lfftc_pkg::cfg_type   cfg_ff, cfg_in;
   lfftc_pkg::req_type   req_data;
   lfftc_pkg::joint_type joint_data;
   lfftc_pkg::rsp_type   rsp_data;
   logic                 joint_valid, joint_ready;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            lfftc_pkg::REG_INERTIA:          cfg_in.inertia = csr_wdata;
            lfftc_pkg::REG_GRAVITY_MOMENT:   cfg_in.gravity_moment = csr_wdata;
            lfftc_pkg::REG_INV_TRANSMISSION: cfg_in.inverse_transmission = csr_wdata;
            lfftc_pkg::REG_DEAD_TORQUE:      cfg_in.dead_torque = csr_wdata;
            lfftc_pkg::REG_VEL_THRESHOLD:    cfg_in.velocity_threshold = csr_wdata[30:0];
            lfftc_pkg::REG_MAX_COMMAND:      cfg_in.max_command = csr_wdata[30:0];
            lfftc_pkg::REG_PERMILLE_SCALE:   cfg_in.permille_per_newton_metre = csr_wdata;
            lfftc_pkg::REG_CLAMP_PERMILLE:   cfg_in.clamp_permille = csr_wdata[14:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lfftc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request
   assign req_data.joint_angle        = req_tdata[15:0];
   assign req_data.joint_acceleration = req_tdata[47:16];
   assign req_data.joint_velocity     = req_tdata[79:48];

   lfftc_joint_path #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .TORQUE_FRAC_BITS(TORQUE_FRAC_BITS)
   ) u_joint_path (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_data),
      .out_valid(joint_valid),
      .out_ready(joint_ready),
      .out_data (joint_data)
   );

   lfftc_motor_path #(
      .TORQUE_FRAC_BITS(TORQUE_FRAC_BITS)
   ) u_motor_path (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (joint_valid),
      .in_ready (joint_ready),
      .in_data  (joint_data),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_data)
   );

   // Pack the result
   assign rsp_tdata = {rsp_data.friction_torque, rsp_data.joint_feedforward_torque,
                       rsp_data.motor_torque_command, rsp_data.torque_permille};

endmodule
